[rtl/sorted_table_binary_search_core_defines.svh]
// assertion macros for the rtl files, included by the probe sequencer
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while in reset
`define STBS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, sampled on clk, off while in reset
`define STBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STBS_ASSERT_IMPL(lbl, ante, cons)
`define STBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/stbs_pkg.sv]
// shared types, constants and helpers of the sorted table search core
package stbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_WIDTH   = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 8;
	localparam int IN_KEY_W    = 32;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [IN_KEY_W-1:0]  in_key_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	// compare result of search key against one table entry
	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

	// table index to memory address, wrapping at the table depth
	function automatic addr_t to_addr(idx_t i);
		logic [ADDR_W+IDX_W-1:0] w;
		w = {{ADDR_W{1'b0}}, i};
		return w[ADDR_W-1:0];
	endfunction

	// port key to stored key width
	function automatic key_t to_key(in_key_t k);
		logic [KEY_WIDTH+IN_KEY_W-1:0] w;
		w = {{KEY_WIDTH{1'b0}}, k};
		return w[KEY_WIDTH-1:0];
	endfunction

	// floor of the midpoint of two indices
	function automatic idx_t mid_of(idx_t a, idx_t b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[IDX_W:1];
	endfunction

endpackage

[rtl/sorted_table_binary_search_core.sv]
// top level of the sorted table binary search core
// write transaction: done in the cycle after start; busy stays low, the sequencer stays idle
// search transaction: probes of the key ram (registered read, one shared comparator) halve
// the lo/hi range, plus one neighbor check when the key lies above the midpoint next to hi;
// with last_index 0 no probe is made; busy holds off the next start until the cycle of done
// reset clears only last_index, state and done; the receiver cannot stall done
module sorted_table_binary_search_core (
	input  logic                     clk,
	input  logic                     arst_n,
	// transaction request
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [7:0]               entry_index,
	input  logic [31:0]              key_value,
	// transaction result
	output logic                     done,
	output logic                     found,
	output logic [7:0]               position,
	// last_index register write
	input  logic                     cfg_we,
	input  logic [7:0]               cfg_wdata
);

	// highest index included in a search; 0 means an empty range
	stbs_pkg::idx_t  last_index_q;

	// key ram ports
	logic            wr_en;
	stbs_pkg::addr_t wr_addr;
	stbs_pkg::key_t  wr_data;
	stbs_pkg::addr_t rd_addr;
	stbs_pkg::key_t  rd_data;

	// shared comparator
	stbs_pkg::key_t  search_key;
	stbs_pkg::cmp_t  cmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
		end else if (cfg_we) begin
			last_index_q <= cfg_wdata;
		end
	end

	// key table, read address driven every cycle by the sequencer
	stbs_ram #(
		.WIDTH(stbs_pkg::KEY_WIDTH),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// compares the held search key with the entry read last cycle
	stbs_cmp u_cmp (
		.key   (search_key),
		.entry (rd_data),
		.res   (cmp)
	);

	// narrows the lo/hi bounds one probe per cycle
	stbs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.entry_index (entry_index),
		.key_value   (key_value),
		.last_index  (last_index_q),
		.cmp         (cmp),
		.key         (search_key),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.done        (done),
		.found       (found),
		.position    (position)
	);

endmodule

[rtl/stbs_ram.sv]
// generic single write port ram with registered read
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/stbs_cmp.sv]
// unsigned key comparator shared by every probe
module stbs_cmp (
	input  stbs_pkg::key_t key,
	input  stbs_pkg::key_t entry,
	output stbs_pkg::cmp_t res
);

	assign res.gt = key > entry;
	assign res.eq = key == entry;

endmodule

[rtl/stbs_seq.sv]
// probe sequencer: bounds, midpoint and result registers
`include "sorted_table_binary_search_core_defines.svh"

module stbs_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              opcode,
	input  stbs_pkg::idx_t    entry_index,
	input  stbs_pkg::in_key_t key_value,
	input  stbs_pkg::idx_t    last_index,
	input  stbs_pkg::cmp_t    cmp,
	output stbs_pkg::key_t    key,
	output logic              wr_en,
	output stbs_pkg::addr_t   wr_addr,
	output stbs_pkg::key_t    wr_data,
	output stbs_pkg::addr_t   rd_addr,
	output logic              busy,
	output logic              done,
	output logic              found,
	output stbs_pkg::idx_t    position
);

	stbs_pkg::state_t state_q, state_d;
	logic             done_q, done_d;
	logic             found_q, found_d;
	stbs_pkg::idx_t   position_q, position_d;
	stbs_pkg::idx_t   hi_q, hi_d, lo_q, lo_d, mid_q, mid_d;
	stbs_pkg::key_t   key_q, key_d;
	stbs_pkg::idx_t   rd_idx;
	logic             hi_is_next;
	logic             accept;

	assign accept     = start && (state_q == stbs_pkg::ST_IDLE);
	assign hi_is_next = ({1'b0, mid_q} + {{stbs_pkg::IDX_W{1'b0}}, 1'b1}) == {1'b0, hi_q};

	// next probe address
	always_comb begin
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				rd_idx = stbs_pkg::mid_of(last_index, '0);
			end
			stbs_pkg::ST_PROBE: begin
				if (cmp.gt) begin
					rd_idx = hi_is_next ? hi_q : stbs_pkg::mid_of(hi_q, mid_q);
				end else begin
					rd_idx = stbs_pkg::mid_of(mid_q, lo_q);
				end
			end
			default: begin
				rd_idx = hi_q;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		done_d     = 1'b0;
		found_d    = found_q;
		position_d = position_q;
		hi_d       = hi_q;
		lo_d       = lo_q;
		mid_d      = mid_q;
		key_d      = key_q;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == stbs_pkg::OP_WRITE) begin
						done_d     = 1'b1;
						found_d    = 1'b0;
						position_d = entry_index;
					end else if (last_index == '0) begin
						// empty range, nothing to compare
						done_d     = 1'b1;
						found_d    = 1'b0;
						position_d = '0;
					end else begin
						hi_d    = last_index;
						lo_d    = '0;
						mid_d   = rd_idx;
						key_d   = stbs_pkg::to_key(key_value);
						state_d = stbs_pkg::ST_PROBE;
					end
				end
			end
			stbs_pkg::ST_PROBE: begin
				if (cmp.eq) begin
					done_d     = 1'b1;
					found_d    = 1'b1;
					position_d = mid_q;
					state_d    = stbs_pkg::ST_IDLE;
				end else if (cmp.gt) begin
					if (hi_is_next) begin
						state_d = stbs_pkg::ST_FINAL;
					end else begin
						lo_d  = mid_q;
						mid_d = rd_idx;
					end
				end else if (mid_q == lo_q) begin
					done_d     = 1'b1;
					found_d    = 1'b0;
					position_d = mid_q;
					state_d    = stbs_pkg::ST_IDLE;
				end else begin
					hi_d  = mid_q;
					mid_d = rd_idx;
				end
			end
			stbs_pkg::ST_FINAL: begin
				// upper neighbor decides; position is hi either way
				done_d     = 1'b1;
				found_d    = cmp.eq;
				position_d = hi_q;
				state_d    = stbs_pkg::ST_IDLE;
			end
			default: begin
				state_d = stbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		found_q    <= found_d;
		position_q <= position_d;
		hi_q       <= hi_d;
		lo_q       <= lo_d;
		mid_q      <= mid_d;
		key_q      <= key_d;
	end

	assign key      = key_q;
	assign wr_en    = accept && (opcode == stbs_pkg::OP_WRITE);
	assign wr_addr  = stbs_pkg::to_addr(entry_index);
	assign wr_data  = stbs_pkg::to_key(key_value);
	assign rd_addr  = stbs_pkg::to_addr(rd_idx);
	assign busy     = state_q != stbs_pkg::ST_IDLE;
	assign done     = done_q;
	assign found    = found_q;
	assign position = position_q;

	`STBS_ASSERT_IMPL(a_probe_bounds, state_q == stbs_pkg::ST_PROBE,
		lo_q < hi_q && mid_q >= lo_q && mid_q < hi_q)
	`STBS_ASSERT_IMPL(a_final_adjacent, state_q == stbs_pkg::ST_FINAL, hi_is_next)
	`STBS_ASSERT_NEXT(a_final_ends, state_q == stbs_pkg::ST_FINAL,
		done_q && state_q == stbs_pkg::ST_IDLE)
	`STBS_ASSERT_NEXT(a_accept_progress, accept, done_q || busy)
	`STBS_ASSERT_IMPL(a_found_in_range, done_q && found_q, position_q <= last_index)

endmodule

[bench/sorted_table_binary_search_core_tb.sv]
// self-checking testbench for the sorted table binary search core
module sorted_table_binary_search_core_tb;

	// rough number of transactions to send before the run winds down
	localparam int ITEM_TARGET  = 1100;
	// cycles with neither an accepted request nor a result before giving up:
	// the longest correct quiet spell is a few idle sender cycles plus one full search
	localparam int STALL_LIMIT  = 500;
	// extra cycles after the last result so that a stray late strobe is still caught
	localparam int TAIL_CYCLES  = 16;

	// one predicted search or write result
	typedef struct packed {
		logic           found;
		stbs_pkg::idx_t position;
	} lookup_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        opcode      = 1'b0;
	logic [7:0]  entry_index = '0;
	logic [31:0] key_value   = '0;
	logic        cfg_we      = 1'b0;
	logic [7:0]  cfg_wdata   = '0;
	logic        busy;
	logic        done;
	logic        found;
	logic [7:0]  position;

	// shadow copy of the key ram and of last_index, updated when a write is accepted or last_index is written
	stbs_pkg::key_t table_shadow [stbs_pkg::TABLE_DEPTH];
	stbs_pkg::idx_t last_index_shadow = '0;
	// predicted results, oldest first
	lookup_t        expected_lookups [$];

	int          error_count  = 0;
	int          sent_count   = 0;
	int          stall_cycles = 0;
	// random idle cycles between requests, switched off for one long stretch
	bit          gaps_on      = 1'b1;

	sorted_table_binary_search_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.entry_index (entry_index),
		.key_value   (key_value),
		.done        (done),
		.found       (found),
		.position    (position),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// binary search over entries 0..last_index, same probe order as the hardware:
	// a hit on the midpoint stops at once, stepping up with one entry left checks hi
	// directly, and a miss lands one past the last smaller midpoint
	function automatic lookup_t predict_lookup(stbs_pkg::key_t key);
		lookup_t     r;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int          order;
		r.found    = 1'b0;
		r.position = '0;
		// empty range: nothing is compared
		if (last_index_shadow == 0)
			return r;
		hi    = last_index_shadow;
		lo    = 0;
		mid   = 0;
		order = 0;
		do begin
			mid   = (hi + lo) / 2;
			order = (key > table_shadow[mid]) ? 1 : (key < table_shadow[mid]) ? -1 : 0;
			if (order > 0) begin
				lo = mid;
				// only hi is left above the midpoint
				if (hi == mid + 1) begin
					if (key == table_shadow[hi]) begin
						r.found    = 1'b1;
						r.position = stbs_pkg::idx_t'(hi);
						return r;
					end
					break;
				end
			end else if (order < 0) begin
				hi = mid;
			end else begin
				r.found    = 1'b1;
				r.position = stbs_pkg::idx_t'(mid);
				return r;
			end
		end while (hi > lo);
		if (order > 0)
			mid++;
		r.position = stbs_pkg::idx_t'(mid);
		return r;
	endfunction

	// a key that keeps the table in order when stored at entry i
	function automatic stbs_pkg::key_t key_between(stbs_pkg::idx_t i);
		longint unsigned lo_k;
		longint unsigned hi_k;
		longint unsigned pick;
		lo_k = (i == 0) ? 64'd0 : 64'(table_shadow[i - 1]);
		hi_k = (i == 8'hFF) ? 64'hFFFF_FFFF : 64'(table_shadow[i + 1]);
		// neighbors already out of order: any key will do
		if (lo_k > hi_k)
			return stbs_pkg::key_t'($urandom);
		pick = {$urandom, $urandom};
		return stbs_pkg::key_t'(lo_k + pick % (hi_k - lo_k + 1));
	endfunction

	// mostly keys that are in the searched range, some just beside one, some anywhere
	function automatic stbs_pkg::key_t pick_search_key();
		stbs_pkg::key_t hit;
		hit = table_shadow[$urandom_range(last_index_shadow, 0)];
		case ($urandom_range(9, 0))
			6: begin
				return stbs_pkg::key_t'(hit + 1);
			end
			7: begin
				return stbs_pkg::key_t'(hit - 1);
			end
			8, 9: begin
				return stbs_pkg::key_t'($urandom);
			end
			default: begin
				return hit;
			end
		endcase
	endfunction

	// send one transaction, wait for it to be taken, then record what it should return
	task automatic issue_request(stbs_pkg::op_t op, stbs_pkg::idx_t idx, stbs_pkg::key_t key);
		lookup_t r;
		// about one idle cycle in three while gaps are on
		while (gaps_on && $urandom_range(99, 0) < 33) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		entry_index <= idx;
		key_value   <= key;
		// start may sit high while the core is still busy with the previous one
		do @(posedge clk); while (busy !== 1'b0);
		if (op == stbs_pkg::OP_WRITE) begin
			table_shadow[idx] = key;
			r.found    = 1'b0;
			r.position = idx;
		end else begin
			r = predict_lookup(key);
		end
		expected_lookups.push_back(r);
		sent_count++;
	endtask

	// stop sending until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_lookups.size() != 0);
	endtask

	// only called with the core idle
	task automatic write_last_index(stbs_pkg::idx_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we            <= 1'b0;
		last_index_shadow  = value;
	endtask

	// last_index is 0 out of reset, so searches compare nothing; writes echo their index
	task automatic test_after_reset();
		issue_request(stbs_pkg::OP_SEARCH, 8'h00, 32'h0000_0000);
		issue_request(stbs_pkg::OP_SEARCH, 8'hFF, 32'hFFFF_FFFF);
		issue_request(stbs_pkg::OP_WRITE, 8'hFF, 32'hFFFF_FFFF);
		issue_request(stbs_pkg::OP_WRITE, 8'h00, 32'h0000_0000);
		issue_request(stbs_pkg::OP_SEARCH, 8'h5A, stbs_pkg::key_t'($urandom));
		drain_results();
	endtask

	// a four entry table: hits on the first probe, a second probe and the neighbor check, below all, between, above all
	task automatic test_small_table();
		stbs_pkg::key_t four_probes [8] = '{32'h20, 32'h40, 32'h10, 32'h05,
		                                    32'h25, 32'h50, 32'h00, 32'hFFFF_FFFF};
		stbs_pkg::key_t two_probes  [4] = '{32'h10, 32'h20, 32'h15, 32'hFFFF_FFFF};
		for (int i = 0; i < 4; i++)
			issue_request(stbs_pkg::OP_WRITE, stbs_pkg::idx_t'(i),
			              stbs_pkg::key_t'(32'h10 * (i + 1)));
		drain_results();
		write_last_index(8'd3);
		foreach (four_probes[i])
			issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::idx_t'($urandom), four_probes[i]);
		drain_results();
		// smallest range that still compares: one probe plus the neighbor check
		write_last_index(8'd1);
		foreach (two_probes[i])
			issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::idx_t'($urandom), two_probes[i]);
		drain_results();
	endtask

	// fill all 256 entries in order (with some duplicates) and search the full range,
	// back to back with no idle cycles
	task automatic test_full_table();
		stbs_pkg::key_t k;
		gaps_on = 1'b0;
		k = stbs_pkg::key_t'($urandom_range(16'hFFFF, 0));
		for (int i = 0; i < stbs_pkg::TABLE_DEPTH; i++) begin
			issue_request(stbs_pkg::OP_WRITE, stbs_pkg::idx_t'(i), k);
			if ($urandom_range(3, 0) != 0)
				k = k + stbs_pkg::key_t'($urandom_range(24'hFF_FFFF, 1));
		end
		drain_results();
		write_last_index(8'hFF);
		issue_request(stbs_pkg::OP_SEARCH, 8'h00, 32'h0000_0000);
		issue_request(stbs_pkg::OP_SEARCH, 8'hFF, 32'hFFFF_FFFF);
		repeat (80)
			issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::idx_t'($urandom), pick_search_key());
		drain_results();
		gaps_on = 1'b1;
	endtask

	// phases with a fresh last_index each; in-order rewrites, the odd out-of-order
	// write, and mostly searches
	task automatic test_random_phases();
		stbs_pkg::idx_t limit;
		stbs_pkg::idx_t idx;
		while (sent_count < ITEM_TARGET) begin
			drain_results();
			case ($urandom_range(7, 0))
				0:       limit = 8'd0;
				1:       limit = 8'd1;
				2:       limit = 8'hFF;
				3:       limit = stbs_pkg::idx_t'($urandom_range(7, 2));
				default: limit = stbs_pkg::idx_t'($urandom);
			endcase
			write_last_index(limit);
			repeat ($urandom_range(40, 10)) begin
				idx = stbs_pkg::idx_t'($urandom);
				case ($urandom_range(19, 0))
					0, 1, 2, 3: begin
						issue_request(stbs_pkg::OP_WRITE, idx, key_between(idx));
					end
					4: begin
						// breaks the ordering: results stay deterministic
						issue_request(stbs_pkg::OP_WRITE, idx, stbs_pkg::key_t'($urandom));
					end
					default: begin
						issue_request(stbs_pkg::OP_SEARCH, idx, pick_search_key());
					end
				endcase
			end
		end
		drain_results();
	endtask

	// every strobed result is checked against the oldest prediction
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_lookups.size() == 0) begin
				$error("result with no transaction pending: found %0b position %0d",
				       found, position);
				error_count++;
			end else begin
				want = expected_lookups.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0b, actual %0b", want.found, found);
					error_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					error_count++;
				end
			end
		end
	end

	// watchdog: restarts on every accepted request or result
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_small_table();
		test_full_table();
		test_random_phases();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sorted_table_binary_search_core.f]
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_cmp.sv
rtl/stbs_seq.sv
rtl/sorted_table_binary_search_core.sv
bench/sorted_table_binary_search_core_tb.sv
